>>> rtl/assert_macros.svh
// assertion macros used by the core of the polyline smoother
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define CPS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cps implication check failed");
`define CPS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cps next-cycle check failed");
`else
`define CPS_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define CPS_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/cps_pkg.sv
`timescale 1ns / 1ps
// types, constants and the corner-cut function of the polyline smoother
// no dependencies
package cps_pkg;

  localparam int MaxPasses  = 5;
  localparam int CoordWidth = 32;
  localparam int PassCntW   = 3;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhFirst = 2'd1,
    PhLater = 2'd2
  } phase_e;

  typedef struct packed {
    logic signed [CoordWidth-1:0] point_x;
    logic signed [CoordWidth-1:0] point_y;
    logic                         is_final;
  } cps_in_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] out_x;
    logic signed [CoordWidth-1:0] out_y;
    logic                         out_final;
  } cps_out_t;

  // point in flight, with one enable bit per pass
  typedef struct packed {
    logic signed [CoordWidth-1:0] x;
    logic signed [CoordWidth-1:0] y;
    logic                         fin;
    logic [MaxPasses-1:0]         act;
  } item_t;

  typedef struct packed {
    logic idle;
    logic pend;
  } stage_stat_t;

  // floor((3*near + far) / 4); the result lies between near and far
  function automatic logic signed [CoordWidth-1:0] cut_point(
    input logic signed [CoordWidth-1:0] near_v,
    input logic signed [CoordWidth-1:0] far_v
  );
    logic signed [CoordWidth+1:0] sum;
    sum = {{2{near_v[CoordWidth-1]}}, near_v}
        + {near_v[CoordWidth-1], near_v, 1'b0}
        + {{2{far_v[CoordWidth-1]}}, far_v};
    return sum[CoordWidth+1:2];
  endfunction

endpackage

>>> rtl/cps_front.sv
`timescale 1ns / 1ps
// front end: pass count register, input capture and per-pass enable tagging
// depends on cps_pkg
module cps_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  cps_pkg::cps_in_t               in_data_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cps_pkg::PassCntW-1:0]   cfg_data_i,
  output logic                           cfg_clear_o,
  output logic                           item_valid_o,
  input  logic                           item_ready_i,
  output cps_pkg::item_t                 item_o
);

  logic [cps_pkg::PassCntW-1:0]  pass_count_q;
  logic                          item_valid_q;
  cps_pkg::item_t                item_q, item_d;
  logic                          take;
  logic [cps_pkg::MaxPasses-1:0] act;

  assign cfg_ready_o  = 1'b1;
  assign cfg_clear_o  = cfg_valid_i;
  assign full_o       = item_valid_q && !item_ready_i;
  assign take         = push_i && !full_o;
  assign item_valid_o = item_valid_q;
  assign item_o       = item_q;

  // counts above the number of stages enable every stage
  always_comb begin
    for (int k = 0; k < cps_pkg::MaxPasses; k++) begin
      act[k] = (pass_count_q > cps_pkg::PassCntW'(k));
    end
    item_d.x   = in_data_i.point_x;
    item_d.y   = in_data_i.point_y;
    item_d.fin = in_data_i.is_final;
    item_d.act = act;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_count_q <= cps_pkg::PassCntW'(1);
      item_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        pass_count_q <= cfg_data_i;
      end
      if (take) begin
        item_valid_q <= 1'b1;
      end else if (item_ready_i) begin
        item_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

endmodule

>>> rtl/cps_queue.sv
`timescale 1ns / 1ps
// short queue that decouples the front end from the smoothing passes
// depends on cps_pkg
module cps_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  cps_pkg::item_t wr_item_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output cps_pkg::item_t rd_item_o
);

  cps_pkg::item_t                 slots_q [cps_pkg::QueueDepth];
  logic [cps_pkg::QueuePtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [cps_pkg::QueueCntW-1:0]  count_q;
  logic                           do_wr, do_rd;

  assign wr_ready_o = (count_q != cps_pkg::QueueCntW'(cps_pkg::QueueDepth));
  assign rd_valid_o = (count_q != '0);
  assign rd_item_o  = slots_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slots_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

>>> rtl/cps_stage.sv
`timescale 1ns / 1ps
// one chaikin pass: keeps the previous point and emits up to two points per input
// depends on cps_pkg
module cps_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clear_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cps_pkg::item_t       in_item_i,
  input  logic                 in_act_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cps_pkg::item_t       out_item_o,
  output cps_pkg::stage_stat_t stat_o
);

  cps_pkg::phase_e                      phase_q, phase_d;
  logic signed [cps_pkg::CoordWidth-1:0] held_x_q, held_y_q;
  logic                                 out_valid_q, pend_valid_q;
  cps_pkg::item_t                       out_q, pend_q;
  cps_pkg::item_t                       r0, r1;
  logic                                 two, hold;
  logic                                 out_free, take;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = !pend_valid_q && out_free;
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign stat_o.idle = (phase_q == cps_pkg::PhIdle);
  assign stat_o.pend = pend_valid_q;

  always_comb begin
    r0      = in_item_i;
    r1      = in_item_i;
    two     = 1'b0;
    hold    = 1'b0;
    phase_d = phase_q;
    if (in_act_i) begin
      case (phase_q)
        cps_pkg::PhIdle: begin
          if (!in_item_i.fin) begin
            hold    = 1'b1;
            phase_d = cps_pkg::PhFirst;
          end
        end
        cps_pkg::PhFirst: begin
          if (in_item_i.fin) begin
            phase_d = cps_pkg::PhIdle;
          end else begin
            r0.x    = cps_pkg::cut_point(in_item_i.x, held_x_q);
            r0.y    = cps_pkg::cut_point(in_item_i.y, held_y_q);
            r0.fin  = 1'b0;
            hold    = 1'b1;
            phase_d = cps_pkg::PhLater;
          end
        end
        default: begin
          r0.x   = cps_pkg::cut_point(held_x_q, in_item_i.x);
          r0.y   = cps_pkg::cut_point(held_y_q, in_item_i.y);
          r0.fin = 1'b0;
          two    = 1'b1;
          if (in_item_i.fin) begin
            // pinned last point follows the last cut
            phase_d = cps_pkg::PhIdle;
          end else begin
            r1.x   = cps_pkg::cut_point(in_item_i.x, held_x_q);
            r1.y   = cps_pkg::cut_point(in_item_i.y, held_y_q);
            r1.fin = 1'b0;
            hold   = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= cps_pkg::PhIdle;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (clear_i) begin
        phase_q <= cps_pkg::PhIdle;
      end else if (take) begin
        phase_q <= phase_d;
      end
      if (out_free) begin
        if (pend_valid_q) begin
          out_valid_q  <= 1'b1;
          pend_valid_q <= 1'b0;
        end else if (take) begin
          out_valid_q  <= 1'b1;
          pend_valid_q <= two;
        end else begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && hold) begin
      held_x_q <= in_item_i.x;
      held_y_q <= in_item_i.y;
    end
    if (out_free) begin
      if (pend_valid_q) begin
        out_q <= pend_q;
      end else if (take) begin
        out_q  <= r0;
        pend_q <= r1;
      end
    end
  end

endmodule

>>> rtl/chaikin_polyline_smoother_core.sv
`timescale 1ns / 1ps
// path: a taken point reaches the result port through the front register, a
// queue slot and one output register per pass
// throughput: one result per cycle on the result port while pop is held; a
// pass that owes the second point of an input takes no new input until it is
// sent; at zero passes a point is taken every cycle while pop is held
// reset: pass count 1, every pass awaiting the first point, the queue empty
`include "assert_macros.svh"

module chaikin_polyline_smoother_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  cps_pkg::cps_in_t             in_data_i,
  output logic                         empty,
  input  logic                         pop,
  output cps_pkg::cps_out_t            out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [cps_pkg::PassCntW-1:0] cfg_data_i
);

  logic                          cfg_clear;
  logic                          front_valid, front_ready;
  cps_pkg::item_t                front_item;
  logic                          stg_valid [cps_pkg::MaxPasses+1];
  logic                          stg_ready [cps_pkg::MaxPasses+1];
  cps_pkg::item_t                stg_item  [cps_pkg::MaxPasses+1];
  cps_pkg::stage_stat_t          stg_stat  [cps_pkg::MaxPasses];
  logic [cps_pkg::MaxPasses-1:0] stage_idle, stage_pend_take;

  cps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .in_data_i    (in_data_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .cfg_clear_o  (cfg_clear),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready),
    .item_o       (front_item)
  );

  cps_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .wr_item_i  (front_item),
    .rd_valid_o (stg_valid[0]),
    .rd_ready_i (stg_ready[0]),
    .rd_item_o  (stg_item[0])
  );

  for (genvar k = 0; k < cps_pkg::MaxPasses; k++) begin : g_pass
    cps_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .clear_i     (cfg_clear),
      .in_valid_i  (stg_valid[k]),
      .in_ready_o  (stg_ready[k]),
      .in_item_i   (stg_item[k]),
      .in_act_i    (stg_item[k].act[k]),
      .out_valid_o (stg_valid[k+1]),
      .out_ready_i (stg_ready[k+1]),
      .out_item_o  (stg_item[k+1]),
      .stat_o      (stg_stat[k])
    );
    assign stage_idle[k]      = stg_stat[k].idle;
    assign stage_pend_take[k] = stg_stat[k].pend && stg_valid[k] && stg_ready[k];
  end

  assign empty                    = !stg_valid[cps_pkg::MaxPasses];
  assign stg_ready[cps_pkg::MaxPasses] = pop;
  assign out_data_o.out_x         = stg_item[cps_pkg::MaxPasses].x;
  assign out_data_o.out_y         = stg_item[cps_pkg::MaxPasses].y;
  assign out_data_o.out_final     = stg_item[cps_pkg::MaxPasses].fin;

  // a configuration write restarts every pass on a new polyline
  `CPS_ASSERT_NXT(a_cfg_restarts_passes, clk_i, rst_ni, cfg_valid_i && cfg_ready_o, &stage_idle)
  // a pass that still owes its second point never takes a new transaction
  `CPS_ASSERT_IMP(a_no_take_while_pending, clk_i, rst_ni, 1'b1, stage_pend_take == '0)
  // the front end reports full only while holding an item the queue refuses
  `CPS_ASSERT_IMP(a_full_means_blocked, clk_i, rst_ni, full, front_valid && !front_ready)

endmodule
